[rtl/bmhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes for the binary min-heap queue
// Transaction payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;

  // Operation codes (anything else is a plain query)
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic                    is_empty;
    logic [COUNT_W-1:0]      entry_count;
    logic [1:0]              status;
  } rsp_t;

endpackage

[rtl/bmhq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram: generic RAM, one write port and two registered read ports
// Read data appears the cycle after the address is presented.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue: fixed-capacity min-heap of signed 32-bit values
//
// Request channel (req_valid / req_stall / req_data) carries one operation:
// push a value, pop the minimum, or query. Response channel (rsp_valid /
// rsp_stall / rsp_data) returns one transaction per request: the minimum
// after the operation (zero when empty), an empty flag, the entry count and
// a status (done, push rejected full, pop on empty ignored).
// One request is worked on at a time; req_stall is high while it runs.
// A push climbs from the new slot toward the root; a pop fetches the last
// entry and sinks it down from the root toward a leaf. Query, full push and
// empty pop go straight to the result. Each level of a sift needs one
// registered read of the heap RAM and one compare/write.
// req_stall drops the cycle after the result is loaded. The result sits in
// an output register; a new request is taken while it waits. If the
// receiver stalls with a result still held, the next result waits in its
// final state until the register frees. Synchronous reset empties the heap;
// RAM contents need no clearing.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bmhq_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bmhq_pkg::rsp_t rsp_data
);

  import bmhq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_PD_LAST = 3'd3;
  localparam logic [2:0] S_PD_LOAD = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    pos, pos_next;
  logic [AW-1:0]    child, child_next;
  logic             right_ok, right_ok_next;
  logic [VAL_W-1:0] mov_val, mov_val_next;
  logic [1:0]       status, status_next;
  logic [VAL_W-1:0] root;

  logic             req_fire, rsp_load;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0] ram_wdata, rdata_a, rdata_b;

  logic [AW-1:0]    pos_m1, parent_idx;
  logic [AW:0]      child_l, child_r, cnt_ext;
  logic             take_r;
  logic [VAL_W-1:0] sel_val;
  logic [AW-1:0]    sel_idx;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_load  = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  // Index arithmetic
  assign pos_m1     = pos - 1'b1;
  assign parent_idx = AW'(pos_m1 >> 1);
  assign child_l    = {pos, 1'b1};
  assign child_r    = child_l + 1'b1;
  assign cnt_ext    = (AW + 1)'(cnt);

  // Compare unit: smaller child choice on descent
  assign take_r  = right_ok && ($signed(rdata_b) < $signed(rdata_a));
  assign sel_val = take_r ? rdata_b : rdata_a;
  assign sel_idx = take_r ? (child + 1'b1) : child;

  bmhq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Sequencer next state and RAM port control
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    child_next    = child;
    right_ok_next = right_ok;
    mov_val_next  = mov_val;
    status_next   = status;
    ram_we        = 1'b0;
    ram_waddr     = pos;
    ram_wdata     = mov_val;
    raddr_a       = parent_idx;
    raddr_b       = child_r[AW-1:0];
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          status_next  = ST_DONE;
          mov_val_next = req_data.value;
          pos_next     = AW'(cnt);
          state_next   = S_FIN;
          if (req_data.operation == OP_PUSH) begin
            if (cnt >= CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              state_next = S_UP_RD;
            end
          end else if (req_data.operation == OP_POP) begin
            if (cnt == '0) begin
              status_next = ST_EMPTY;
            end else begin
              state_next = S_PD_LAST;
            end
          end
        end
      end
      // Sift up: fetch parent, or settle at the root
      S_UP_RD: begin
        raddr_a = parent_idx;
        if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if ($signed(mov_val) < $signed(rdata_a)) begin
          ram_wdata  = rdata_a;
          pos_next   = parent_idx;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      // Pop: fetch the last entry (count already decremented)
      S_PD_LAST: begin
        raddr_a    = AW'(cnt);
        state_next = S_PD_LOAD;
      end
      S_PD_LOAD: begin
        mov_val_next = rdata_a;
        pos_next     = '0;
        state_next   = S_DN_RD;
      end
      // Sift down: fetch both children, or settle at a leaf
      S_DN_RD: begin
        raddr_a       = child_l[AW-1:0];
        raddr_b       = child_r[AW-1:0];
        child_next    = child_l[AW-1:0];
        right_ok_next = (child_r < cnt_ext);
        if (child_l >= cnt_ext) begin
          ram_we     = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if ($signed(mov_val) <= $signed(sel_val)) begin
          state_next = S_FIN;
        end else begin
          ram_wdata  = sel_val;
          pos_next   = sel_idx;
          state_next = S_DN_RD;
        end
      end
      S_FIN: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && req_data.operation == OP_PUSH && cnt < CNT_W'(CAPACITY)) begin
        cnt <= cnt + 1'b1;
      end else if (req_fire && req_data.operation == OP_POP && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    child    <= child_next;
    right_ok <= right_ok_next;
    mov_val  <= mov_val_next;
    status   <= status_next;
    // Shadow of slot zero for the minimum
    if (ram_we && ram_waddr == '0) begin
      root <= ram_wdata;
    end
    if (rsp_load) begin
      rsp_data.top_value   <= (cnt == '0) ? '0 : $signed(root);
      rsp_data.is_empty    <= (cnt == '0);
      rsp_data.entry_count <= COUNT_W'(cnt);
      rsp_data.status      <= status;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> pos != '0)
    else $error("parent compare issued at the root");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_data.operation == OP_POP && cnt == '0)
      |=> (state == S_FIN && status == ST_EMPTY && cnt == '0))
    else $error("pop on empty heap not ignored");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_data.operation == OP_PUSH && cnt < CNT_W'(CAPACITY))
      |=> (cnt == $past(cnt) + 1'b1 && state == S_UP_RD))
    else $error("push did not take a slot");

endmodule

[tb/binary_min_heap_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb: self-checking bench for the min-heap queue
// A short table of directed transactions covers the empty heap, the value
// extremes, equal values and every operation code. Random phases follow that
// fill, drain and mix the heap, so it runs through full and empty many times.
// Every response is checked field by field against a behavioural heap kept in
// the bench, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

  import bmhq_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 1880;
  localparam int SETTLE_WAIT  = 40;      // comfortably above the longest pop
  localparam int HOLDOFF_LEN  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // Codes the package leaves to the default branch
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} mix_t;
  typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t typed_rsp;
  } stim_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // Bench copy of the heap
  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  int heap_fill = 0;

  rsp_t outcome_q [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int accepted_total = 0;
  int push_total     = 0;
  int pop_total      = 0;
  int query_total    = 0;
  int full_rejects   = 0;
  int empty_pops     = 0;
  int peak_fill      = 0;
  int burst_left     = 0;
  int cycle_count    = 0;
  logic holdoff_on   = 1'b0;

  rx_mode_t rx_mode  = RX_FREE;
  int rx_left        = 0;
  int rx_phase       = 0;
  logic rx_stall_now;

  binary_min_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one operation to the bench heap and return the view after it
  function automatic rsp_t apply_heap_op(req_t item);
    rsp_t view;
    int slot;
    int up;
    int child;
    logic signed [VAL_W-1:0] moving;
    view = '0;
    view.status = ST_DONE;
    if (item.operation == OP_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        view.status = ST_FULL;
      end else begin
        slot = heap_fill;
        moving = item.value;
        while (slot > 0) begin
          up = (slot - 1) / 2;
          if (!(moving < heap_mem[up])) break;
          heap_mem[slot] = heap_mem[up];
          slot = up;
        end
        heap_mem[slot] = moving;
        heap_fill++;
      end
    end else if (item.operation == OP_POP) begin
      if (heap_fill == 0) begin
        view.status = ST_EMPTY;
      end else begin
        heap_fill--;
        moving = heap_mem[heap_fill];
        slot = 0;
        forever begin
          child = 2 * slot + 1;
          if (child >= heap_fill) break;
          // right child only when strictly smaller
          if (child + 1 < heap_fill && heap_mem[child + 1] < heap_mem[child]) child++;
          if (moving <= heap_mem[child]) break;
          heap_mem[slot] = heap_mem[child];
          slot = child;
        end
        heap_mem[slot] = moving;
      end
    end
    if (heap_fill == 0) begin
      view.top_value = '0;
      view.is_empty  = 1'b1;
    end else begin
      view.top_value = heap_mem[0];
      view.is_empty  = 1'b0;
    end
    view.entry_count = COUNT_W'(heap_fill);
    return view;
  endfunction

  function automatic stim_row_t stim(logic [1:0] op, logic signed [VAL_W-1:0] val);
    stim_row_t row;
    row.item.operation = op;
    row.item.value     = val;
    row.typed          = 1'b0;
    row.typed_rsp      = '0;
    return row;
  endfunction

  function automatic stim_row_t stim_g(logic [1:0] op, logic signed [VAL_W-1:0] val,
                                       logic signed [VAL_W-1:0] top, logic empty,
                                       int cnt, logic [1:0] st);
    stim_row_t row;
    row = stim(op, val);
    row.typed                 = 1'b1;
    row.typed_rsp.top_value   = top;
    row.typed_rsp.is_empty    = empty;
    row.typed_rsp.entry_count = COUNT_W'(cnt);
    row.typed_rsp.status      = st;
    return row;
  endfunction

  function automatic logic [1:0] pick_op(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     return (r < 85) ? OP_PUSH : (r < 95) ? OP_POP :
                           (r < 98) ? OP_QUERY : OP_SPARE;
      MIX_DRAIN:    return (r < 85) ? OP_POP : (r < 95) ? OP_PUSH :
                           (r < 98) ? OP_QUERY : OP_SPARE;
      MIX_BALANCED: return (r < 45) ? OP_PUSH : (r < 90) ? OP_POP :
                           (r < 95) ? OP_QUERY : OP_SPARE;
      default:      return 2'($urandom_range(0, 3));
    endcase
  endfunction

  // Mix of wide values, a narrow band for ties, and the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 15)) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      8:          return ($urandom_range(0, 1) == 0) ? VAL_MIN + $urandom_range(0, 3)
                                                      : VAL_MAX - $urandom_range(0, 3);
      default:    return $signed($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  // Offer one transaction and hold it until taken
  task automatic offer(input req_t item, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_heap_op(item);
    outcome_q.push_back(typed ? typed_rsp : predicted);
    accepted_total++;
    case (item.operation)
      OP_PUSH: push_total++;
      OP_POP:  pop_total++;
      default: query_total++;
    endcase
    if (predicted.status == ST_FULL)  full_rejects++;
    if (predicted.status == ST_EMPTY) empty_pops++;
    if (heap_fill > peak_fill) peak_fill = heap_fill;
  endtask

  // Sender bursts: valid drops only when a gap actually starts
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stimulus: directed table, then random phases, then wind down
  initial begin : sender
    stim_row_t directed_rows [24];
    req_t item;
    mix_t mix;
    int mix_left;
    int rnd_sent;
    directed_rows = '{
      stim_g(OP_QUERY, 0,             '0,      1'b1, 0, ST_DONE),
      stim_g(OP_POP,   32'sh1234_5678, '0,     1'b1, 0, ST_EMPTY),
      stim_g(OP_PUSH,  VAL_MAX,       VAL_MAX, 1'b0, 1, ST_DONE),
      stim_g(OP_PUSH,  VAL_MIN,       VAL_MIN, 1'b0, 2, ST_DONE),
      stim(OP_PUSH,  0),
      stim(OP_PUSH,  -1),
      stim(OP_PUSH,  -1),                  // tie with a non-root entry
      stim(OP_PUSH,  VAL_MIN),             // tie with the root
      stim(OP_SPARE, 32'shA5A5_5A5A),
      stim(OP_QUERY, -1),
      stim(OP_POP,   0),
      stim(OP_POP,   0),
      stim(OP_POP,   0),
      stim(OP_PUSH,  1),
      stim(OP_PUSH,  1),
      stim(OP_PUSH,  VAL_MIN + 1),
      stim(OP_POP,   -1),
      stim(OP_POP,   VAL_MAX),
      stim(OP_POP,   VAL_MIN),
      stim(OP_POP,   0),
      stim(OP_POP,   32'sh5555_AAAA),
      stim(OP_POP,   0),                   // last entry leaves
      stim_g(OP_POP,   VAL_MAX,       '0,      1'b1, 0, ST_EMPTY),
      stim_g(OP_SPARE, -1,            '0,      1'b1, 0, ST_DONE)
    };

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].typed_rsp);
      pace();
    end

    rnd_sent = 0;
    mix_left = 0;
    mix = MIX_FILL;
    while (rnd_sent < RANDOM_ITEMS) begin
      if (mix_left == 0) begin
        mix = mix_t'($urandom_range(0, 3));
        mix_left = $urandom_range(20, 120);
      end
      item.operation = pick_op(mix);
      item.value     = pick_value();
      offer(item, 1'b0, '0);
      pace();
      rnd_sent++;
      mix_left--;
    end
    req_valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Run: %0d transactions (%0d push, %0d pop, %0d query), %0d responses checked",
             accepted_total, push_total, pop_total, query_total, results_seen);
    $display("Run: %0d pushes refused on full, %0d pops on empty, peak depth %0d, %0d mismatches",
             full_rejects, empty_pops, peak_fill, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Long receiver hold-off once the run is under way, so the input backs up
  initial begin : holdoff
    @(posedge clk);
    while (accepted_total < 400) @(posedge clk);
    holdoff_on <= 1'b1;
    repeat (HOLDOFF_LEN) @(posedge clk);
    holdoff_on <= 1'b0;
  end

  // Receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_FREE:     rx_stall_now = 1'b0;
      RX_SPARSE:   rx_stall_now = ($urandom_range(0, 3) == 0);
      RX_PERIODIC: rx_stall_now = ((rx_phase % 5) >= 3);
      default:     rx_stall_now = ($urandom_range(0, 3) != 0);
    endcase
    rsp_stall <= holdoff_on | rx_stall_now;
  end

  // Response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: response with none outstanding: top=%0d empty=%0b count=%0d st=%0d",
                   rsp_data.top_value, rsp_data.is_empty, rsp_data.entry_count,
                   rsp_data.status);
      end else begin
        want = outcome_q.pop_front();
        if (rsp_data.top_value !== want.top_value || rsp_data.is_empty !== want.is_empty ||
            rsp_data.entry_count !== want.entry_count || rsp_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("ERROR: response %0d: expected top=%0d empty=%0b count=%0d st=%0d, got top=%0d empty=%0b count=%0d st=%0d",
                     results_seen, want.top_value, want.is_empty, want.entry_count,
                     want.status, rsp_data.top_value, rsp_data.is_empty,
                     rsp_data.entry_count, rsp_data.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timed out after %0d cycles, %0d responses outstanding",
               cycle_count, outcome_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
